>>> rtl/wrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wrd_pkg;

  localparam int unsigned WORDS     = 16;
  localparam int unsigned PTR_W     = 4;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BOUND_W   = 33;
  localparam int unsigned DIV_CNT_W = 6;

  // operation codes
  localparam logic [1:0] OP_RAW   = 2'd0;
  localparam logic [1:0] OP_RANGE = 2'd1;
  localparam logic [1:0] OP_SEED  = 2'd2;

  // result select codes
  localparam logic [1:0] RES_ZERO  = 2'd0;
  localparam logic [1:0] RES_WORD  = 2'd1;
  localparam logic [1:0] RES_RANGE = 2'd2;
  localparam logic [1:0] RES_ERR   = 2'd3;

  // generator tap offsets and tempering mask
  localparam logic [PTR_W-1:0]  OFF_C = 4'd13;
  localparam logic [PTR_W-1:0]  OFF_E = 4'd9;
  localparam logic [PTR_W-1:0]  OFF_Q = 4'd15;
  localparam logic [WORD_W-1:0] WELL_TEMPER = 32'hDA44_2D24;

  localparam logic [BOUND_W-1:0]   SPAN_FULL = 33'h1_0000_0000;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd33;

  typedef struct packed {
    logic       cap_in;
    logic       rd_hi;
    logic       cap_b;
    logic       calc;
    logic       wrq;
    logic       seed;
    logic       div_span;
    logic       div_x;
    logic       cap_lim;
    logic       load_out;
    logic [1:0] res_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       range_bad;
    logic       x_ge_lim;
    logic       div_done;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/wrd_div.sv
`timescale 1ns / 1ps
`default_nettype none
module wrd_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [wrd_pkg::BOUND_W-1:0] dividend,
  input  wire logic [wrd_pkg::BOUND_W-1:0] divisor,
  output logic                             done,
  output logic [wrd_pkg::BOUND_W-1:0]      quot,
  output logic [wrd_pkg::BOUND_W-1:0]      rem
);
  import wrd_pkg::*;

  logic [BOUND_W-1:0]   rem_r, rem_nxt;
  logic [BOUND_W-1:0]   q_r, q_nxt;
  logic [BOUND_W-1:0]   d_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [BOUND_W:0]     trial;
  logic [BOUND_W:0]     diff;
  logic                 ge;

  // one restoring step per cycle
  always_comb begin
    trial    = {rem_r, q_r[BOUND_W-1]};
    ge       = trial >= {1'b0, d_r};
    diff     = trial - {1'b0, d_r};
    rem_nxt  = ge ? diff[BOUND_W-1:0] : trial[BOUND_W-1:0];
    q_nxt    = {q_r[BOUND_W-2:0], ge};
    cnt_nxt  = cnt_r - DIV_CNT_W'(1);
    busy_nxt = busy_r && (cnt_r != DIV_CNT_W'(1));
    done_nxt = busy_r && (cnt_r == DIV_CNT_W'(1));
    if (start) begin
      cnt_nxt  = DIV_STEPS;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (start || busy_r) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      d_r   <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

>>> rtl/wrd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module wrd_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire wrd_pkg::cmd_t               cmd,
  output wrd_pkg::sts_t                    sts,
  input  wire logic [1:0]                  in_operation,
  input  wire logic [wrd_pkg::BOUND_W-1:0] in_range_low,
  input  wire logic [wrd_pkg::BOUND_W-1:0] in_range_high,
  input  wire logic [wrd_pkg::PTR_W-1:0]   in_seed_index,
  input  wire logic [wrd_pkg::WORD_W-1:0]  in_seed_word,
  output logic [wrd_pkg::WORD_W-1:0]       out_random_value,
  output logic                             out_range_error
);
  import wrd_pkg::*;

  logic [WORD_W-1:0]  mem [WORDS];
  logic [WORDS-1:0]   valid_r;
  logic [WORD_W-1:0]  rd0_r, rd1_r;
  logic               v0_r, v1_r;
  logic [WORD_W-1:0]  rd0, rd1;
  logic [PTR_W-1:0]   ra0, ra1, wa;
  logic [WORD_W-1:0]  wd;
  logic               we;

  logic [1:0]         op_r;
  logic [BOUND_W-1:0] low_r, high_r;
  logic [PTR_W-1:0]   sidx_r;
  logic [WORD_W-1:0]  sword_r;
  logic [PTR_W-1:0]   ptr_r;
  logic [WORD_W-1:0]  b_r, word_r;
  logic [BOUND_W-1:0] lim_r, i_r;
  logic [WORD_W-1:0]  val_r, val_nxt;
  logic               err_r, err_nxt;

  logic [WORD_W-1:0]  b_calc, c_v, a_v, d_v, new_v;
  logic [BOUND_W-1:0] span;
  logic               div_start, div_done;
  logic [BOUND_W-1:0] div_a, div_b, div_q, div_rem;

  // read addresses: first pair p, p+13; second pair p+9, p+15
  assign ra0 = cmd.rd_hi ? ptr_r + OFF_E : ptr_r;
  assign ra1 = cmd.rd_hi ? ptr_r + OFF_Q : ptr_r + OFF_C;

  always_ff @(posedge clk) begin
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    v0_r <= valid_r[ra0];
    v1_r <= valid_r[ra1];
  end

  // words never written read as zero
  assign rd0 = v0_r ? rd0_r : '0;
  assign rd1 = v1_r ? rd1_r : '0;

  always_comb begin
    we = 1'b0;
    wa = ptr_r;
    wd = a_v;
    if (cmd.calc) begin
      we = 1'b1;
    end else if (cmd.wrq) begin
      we = 1'b1;
      wa = ptr_r + OFF_Q;
      wd = word_r;
    end else if (cmd.seed) begin
      we = 1'b1;
      wa = sidx_r;
      wd = sword_r;
    end
  end

  // generator step, split over the two read phases
  always_comb begin
    b_calc = rd0 ^ rd1 ^ (rd0 << 16) ^ (rd1 << 15);
    c_v    = rd0 ^ (rd0 >> 11);
    a_v    = b_r ^ c_v;
    d_v    = a_v ^ ((a_v << 5) & WELL_TEMPER);
    new_v  = rd1 ^ b_r ^ d_v ^ (rd1 << 2) ^ (b_r << 18) ^ (c_v << 28);
  end

  assign span = high_r - low_r;

  assign div_start = cmd.div_span || cmd.div_x;
  assign div_a     = cmd.div_span ? SPAN_FULL : {1'b0, word_r};
  assign div_b     = cmd.div_span ? span : i_r;

  wrd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  always_comb begin
    sts.op        = op_r;
    sts.range_bad = (high_r <= low_r) || (span[BOUND_W-1] && (|span[BOUND_W-2:0]));
    sts.x_ge_lim  = {1'b0, word_r} >= lim_r;
    sts.div_done  = div_done;
  end

  always_comb begin
    case (cmd.res_sel)
      RES_WORD: begin
        val_nxt = word_r;
        err_nxt = 1'b0;
      end
      RES_RANGE: begin
        val_nxt = div_q[WORD_W-1:0] + low_r[WORD_W-1:0];
        err_nxt = 1'b0;
      end
      RES_ERR: begin
        val_nxt = '0;
        err_nxt = 1'b1;
      end
      default: begin
        val_nxt = '0;
        err_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ptr_r   <= '0;
    end else begin
      if (we) valid_r[wa] <= 1'b1;
      if (cmd.wrq) ptr_r <= ptr_r + OFF_Q;
      else if (cmd.seed) ptr_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      op_r    <= in_operation;
      low_r   <= in_range_low;
      high_r  <= in_range_high;
      sidx_r  <= in_seed_index;
      sword_r <= in_seed_word;
    end
    if (cmd.cap_b) b_r <= b_calc;
    if (cmd.calc) word_r <= new_v;
    if (cmd.cap_lim) begin
      lim_r <= SPAN_FULL - div_rem;
      i_r   <= div_q;
    end
    if (cmd.load_out) begin
      val_r <= val_nxt;
      err_r <= err_nxt;
    end
  end

  assign out_random_value = val_r;
  assign out_range_error  = err_r;

endmodule
`default_nettype wire

>>> rtl/wrd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module wrd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire wrd_pkg::sts_t sts,
  output wrd_pkg::cmd_t      cmd
);
  import wrd_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_RD1  = 4'd2;
  localparam logic [3:0] S_RD2  = 4'd3;
  localparam logic [3:0] S_CALC = 4'd4;
  localparam logic [3:0] S_WRQ  = 4'd5;
  localparam logic [3:0] S_DIVS = 4'd6;
  localparam logic [3:0] S_DIVX = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [1:0] res_sel_r, res_sel_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    res_sel_nxt   = res_sel_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        cmd.cap_in = in_valid;
        if (in_valid) state_nxt = S_DISP;
      end
      S_DISP: begin
        case (sts.op)
          OP_RAW: begin
            res_sel_nxt = RES_WORD;
            state_nxt   = S_RD1;
          end
          OP_RANGE: begin
            if (sts.range_bad) begin
              res_sel_nxt = RES_ERR;
              state_nxt   = S_FIN;
            end else begin
              cmd.div_span = 1'b1;
              state_nxt    = S_DIVS;
            end
          end
          OP_SEED: begin
            cmd.seed    = 1'b1;
            res_sel_nxt = RES_ZERO;
            state_nxt   = S_FIN;
          end
          default: begin
            res_sel_nxt = RES_ZERO;
            state_nxt   = S_FIN;
          end
        endcase
      end
      S_DIVS: begin
        if (sts.div_done) begin
          cmd.cap_lim = 1'b1;
          res_sel_nxt = RES_RANGE;
          state_nxt   = S_RD1;
        end
      end
      S_RD1: begin
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.rd_hi = 1'b1;
        cmd.cap_b = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_WRQ;
      end
      S_WRQ: begin
        cmd.wrq = 1'b1;
        if (res_sel_r == RES_WORD) begin
          state_nxt = S_FIN;
        end else if (sts.x_ge_lim) begin
          state_nxt = S_RD1;
        end else begin
          cmd.div_x = 1'b1;
          state_nxt = S_DIVX;
        end
      end
      S_DIVX: begin
        if (sts.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.res_sel = res_sel_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_sel_r   <= RES_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_sel_r   <= res_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> rtl/well512_ranged_random_draw.sv
// WELL512 random generator with an unbiased ranged draw.
//
// Input channel (in_valid / in_stall): one word per item, carrying an
// operation (raw draw, ranged draw, seed write) and its operands. Output
// channel (out_valid / out_stall): exactly one word per item, the drawn
// value and a range error flag.
//
// One item is worked on at a time; in_stall is high from the cycle after
// acceptance until the result is loaded into the output register.
// Steps, using the two-port state memory and the one-bit-per-cycle divider:
//   seed write or refused range : decode, then load the result
//   raw draw                    : decode, one generator step, load
//   ranged draw                 : decode, span division, one generator step
//                                 per rejected word plus one, division, load
// Each generator step has two read phases and two writes.
// A finished result sits in the output register; the next item is taken
// while it waits. If the receiver stalls, the result holds, and a second
// finished result waits in the block until the register frees.
// Reset (synchronous, active low) marks the state words unwritten, so they
// read as zero, sets the draw pointer to zero and drops out_valid.
`timescale 1ns / 1ps
`default_nettype none
module well512_ranged_random_draw (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [32:0] in_range_low,
  input  wire logic [32:0] in_range_high,
  input  wire logic [3:0]  in_seed_index,
  input  wire logic [31:0] in_seed_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_random_value,
  output logic             out_range_error
);
  import wrd_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: decodes the word, runs generator steps, redraws, divides
  wrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: state memory, generator logic, shared divider, output register
  wrd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_range_low     (in_range_low),
    .in_range_high    (in_range_high),
    .in_seed_index    (in_seed_index),
    .in_seed_word     (in_seed_word),
    .out_random_value (out_random_value),
    .out_range_error  (out_range_error)
  );

endmodule
`default_nettype wire

>>> rtl/wrd_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module wrd_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_operation,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_random_value,
  input wire logic        out_range_error
);
  import wrd_pkg::*;

  // reset drops the output word
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // an accepted word makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in flight");

  // a refused range carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |-> (out_random_value == '0))
    else $error("range error with nonzero value");

  // a seed write accepted while no result waits is followed by its result
  a_seed_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_operation == OP_SEED) && !out_valid)
      |=> ##2 out_valid)
    else $error("seed write result late");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_random_value)
      && $stable(out_range_error)))
    else $error("stalled output changed");

endmodule

bind well512_ranged_random_draw wrd_chk u_wrd_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_operation     (in_operation),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_random_value (out_random_value),
  .out_range_error  (out_range_error)
);
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import wrd_pkg::*;

  // operation 3 has no package name; the block must ignore it
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          RANDOM_WORDS = 1900;
  localparam int          LONG_HOLD    = 400;
  localparam int          DRAIN_CYCLES = 200;
  localparam int          MAX_REPORTS  = 100;
  localparam logic [32:0] BOUND_MAX    = 33'h1_FFFF_FFFF;

  // One stimulus word. Rows with typed set carry an expected result that is
  // obvious by inspection; every other row is checked against the predictor.
  typedef struct packed {
    logic [1:0]  op;
    logic [32:0] low;
    logic [32:0] high;
    logic [3:0]  idx;
    logic [31:0] word;
    logic        typed;
    logic [31:0] value;
    logic        err;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] value;
    logic        err;
  } draw_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = '0;
  logic [32:0] in_range_low = '0;
  logic [32:0] in_range_high = '0;
  logic [3:0]  in_seed_index = '0;
  logic [31:0] in_seed_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_random_value;
  logic        out_range_error;

  // Predictor copy of the generator: sixteen state words and the pointer.
  logic [31:0] gen_words [16];
  logic [3:0]  gen_ptr;

  draw_result_t expected_draws [$];
  int          fail_count = 0;

  // Idling controls shared between the stimulus and the result sink.
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit long_hold_req = 1'b0;

  always #2 clk = ~clk;

  well512_ranged_random_draw dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_range_low     (in_range_low),
    .in_range_high    (in_range_high),
    .in_seed_index    (in_seed_index),
    .in_seed_word     (in_seed_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_random_value (out_random_value),
    .out_range_error  (out_range_error)
  );

  // Advance the generator once and return the new word.
  function automatic logic [31:0] well_step();
    logic [3:0]  p, pc, pe, q;
    logic [31:0] a, b, c, d;
    p  = gen_ptr;
    pc = p + OFF_C;
    pe = p + OFF_E;
    q  = p + OFF_Q;
    a  = gen_words[p];
    c  = gen_words[pc];
    b  = a ^ c ^ (a << 16) ^ (c << 15);
    c  = gen_words[pe];
    c  = c ^ (c >> 11);
    a  = b ^ c;
    gen_words[p] = a;
    d  = a ^ ((a << 5) & WELL_TEMPER);
    gen_ptr = q;
    a  = gen_words[q];
    gen_words[q] = a ^ b ^ d ^ (a << 2) ^ (b << 18) ^ (c << 28);
    return gen_words[q];
  endfunction

  // Work out the result of one accepted word and update the predictor state.
  function automatic draw_result_t predict_draw(logic [1:0] op, logic [32:0] lo,
                                                logic [32:0] hi, logic [3:0] idx,
                                                logic [31:0] w);
    draw_result_t r;
    logic [63:0]  span, per, lim, x, v;
    r = '0;
    case (op)
      OP_RAW: r.value = well_step();
      OP_RANGE: begin
        span = {31'd0, hi} - {31'd0, lo};
        if (hi <= lo || span > {31'd0, SPAN_FULL}) begin
          r.err = 1'b1;
        end else begin
          per = 64'h1_0000_0000 / span;
          lim = per * span;
          // redraw until the word falls below the largest multiple of span
          x = {32'd0, well_step()};
          while (x >= lim) x = {32'd0, well_step()};
          v = x / per + {31'd0, lo};
          r.value = v[31:0];
        end
      end
      OP_SEED: begin
        gen_words[idx] = w;
        gen_ptr = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic stim_row_t row(logic [1:0] op, logic [32:0] lo, logic [32:0] hi,
                                    logic [3:0] idx, logic [31:0] w);
    stim_row_t s;
    s = '0;
    s.op = op;
    s.low = lo;
    s.high = hi;
    s.idx = idx;
    s.word = w;
    return s;
  endfunction

  function automatic stim_row_t fixed_row(logic [1:0] op, logic [32:0] lo,
                                          logic [32:0] hi, logic [3:0] idx,
                                          logic [31:0] w, logic [31:0] value,
                                          logic err);
    stim_row_t s;
    s = row(op, lo, hi, idx, w);
    s.typed = 1'b1;
    s.value = value;
    s.err = err;
    return s;
  endfunction

  // Fill every field with noise so unused fields toggle all their bits too.
  function automatic stim_row_t noise_row();
    return row(2'($urandom_range(0, 3)), {1'($urandom_range(0, 1)), $urandom},
               {1'($urandom_range(0, 1)), $urandom}, 4'($urandom_range(0, 15)),
               $urandom);
  endfunction

  function automatic int idle_len();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Pick ranged-draw bounds: mostly legal spans of every size, some with
  // heavy rejection, some empty or inverted, some wider than 2^32.
  task automatic pick_bounds(output logic [32:0] lo, output logic [32:0] hi);
    logic [33:0] s, l, h;
    int          k;
    k = $urandom_range(0, 99);
    if (k < 88) begin
      if (k < 30) s = 34'($urandom_range(1, 64));
      else if (k < 60) s = {2'b00, $urandom} + 34'd1;
      else if (k < 72) begin
        s = (34'd1 << $urandom_range(0, 32)) + 34'($urandom_range(0, 2)) - 34'd1;
        if (s == 0) s = 34'd1;
        if (s > 34'h1_0000_0000) s = 34'h1_0000_0000;
      end
      else if (k < 80) s = 34'h0_8000_0000 + 34'($urandom_range(1, 1000));
      else s = 34'h1_0000_0000 - 34'($urandom_range(0, 1000));
      l = {1'b0, 1'($urandom_range(0, 1)), $urandom};
      if (l + s > {1'b0, BOUND_MAX}) l = {1'b0, BOUND_MAX} - s;
      h = l + s;
    end else if (k < 95) begin
      // empty or inverted range
      l = {1'b0, 1'($urandom_range(0, 1)), $urandom};
      h = {1'b0, 1'($urandom_range(0, 1)), $urandom};
      if ($urandom_range(0, 3) == 0) h = l;
      if (h > l) begin
        s = h;
        h = l;
        l = s;
      end
    end else begin
      // span above 2^32
      l = {2'b00, $urandom_range(0, 32'h7FFF_FFFF)};
      h = l + 34'h1_0000_0001 + 34'($urandom_range(0, 32'h7FFF_FFFE));
    end
    lo = l[32:0];
    hi = h[32:0];
  endtask

  // Offer one word, hold it until accepted, record its expected result, then
  // idle for a random gap.
  task automatic offer_word(input stim_row_t s);
    draw_result_t res;
    int           gap;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_operation  <= s.op;
    in_range_low  <= s.low;
    in_range_high <= s.high;
    in_seed_index <= s.idx;
    in_seed_word  <= s.word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = predict_draw(s.op, s.low, s.high, s.idx, s.word);
    if (s.typed) begin
      res.value = s.value;
      res.err = s.err;
    end
    expected_draws.push_back(res);
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid and hold off until every expected result has arrived.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
  endtask

  // Result sink: stall at random, sometimes for a long stretch, and run calm
  // when asked. One assignment to out_stall per falling edge.
  initial begin : result_sink
    int stall_left;
    int r;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rx_calm) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          stall_left = (r < 96) ? $urandom_range(0, 3) : $urandom_range(15, 60);
        end
      end
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin : check_results
    draw_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_draws.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $error("unexpected result word: random_value %h range_error %b",
                 out_random_value, out_range_error);
      end else begin
        want = expected_draws.pop_front();
        if (out_random_value !== want.value) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("random_value: expected %h, got %h", want.value, out_random_value);
        end
        if (out_range_error !== want.err) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("range_error: expected %b, got %b", want.err, out_range_error);
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t directed [$];
    stim_row_t s;
    int        n_rand;
    int        r;
    int        k;
    bit        hold_done;
    bit        paused;

    for (k = 0; k < 16; k++) gen_words[k] = '0;
    gen_ptr = '0;
    n_rand = 0;
    hold_done = 1'b0;
    paused = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A zeroed generator yields zero words, so draws before
    // any seed write are known by inspection.
    directed.push_back(fixed_row(OP_RAW, '0, '0, '0, '0, 32'd0, 1'b0));
    directed.push_back(fixed_row(OP_RANGE, 33'd5, 33'd10, '0, '0, 32'd5, 1'b0));
    // empty range, inverted range, oversized span: refused, no advance
    directed.push_back(fixed_row(OP_RANGE, 33'd7, 33'd7, '0, '0, 32'd0, 1'b1));
    directed.push_back(fixed_row(OP_RANGE, 33'd9, 33'd3, '0, '0, 32'd0, 1'b1));
    directed.push_back(fixed_row(OP_RANGE, '0, BOUND_MAX, '0, '0, 32'd0, 1'b1));
    directed.push_back(fixed_row(OP_RANGE, BOUND_MAX, '0, 4'hF, '1, 32'd0, 1'b1));
    directed.push_back(fixed_row(OP_UNUSED, BOUND_MAX, BOUND_MAX, 4'hF, '1, 32'd0,
                                 1'b0));
    // seed writes at both index extremes and both word extremes
    directed.push_back(fixed_row(OP_SEED, '0, '0, 4'h0, 32'hFFFF_FFFF, 32'd0, 1'b0));
    directed.push_back(fixed_row(OP_SEED, BOUND_MAX, BOUND_MAX, 4'hF, 32'h0, 32'd0,
                                 1'b0));
    directed.push_back(fixed_row(OP_SEED, '0, '0, 4'h5, 32'h1234_5678, 32'd0, 1'b0));
    directed.push_back(fixed_row(OP_SEED, '0, '0, 4'hA, 32'h8000_0001, 32'd0, 1'b0));
    directed.push_back(row(OP_RAW, '0, '0, '0, '0));
    directed.push_back(row(OP_RAW, BOUND_MAX, BOUND_MAX, 4'hF, '1));
    // full 2^32 span returns the word itself
    directed.push_back(row(OP_RANGE, '0, SPAN_FULL, '0, '0));
    // span of one: the result is the low bound, kept to 32 bits
    directed.push_back(fixed_row(OP_RANGE, '0, 33'd1, '0, '0, 32'd0, 1'b0));
    directed.push_back(fixed_row(OP_RANGE, 33'h0_FFFF_FFFF, SPAN_FULL, '0, '0,
                                 32'hFFFF_FFFF, 1'b0));
    directed.push_back(fixed_row(OP_RANGE, BOUND_MAX - 33'd1, BOUND_MAX, '0, '0,
                                 32'hFFFF_FFFE, 1'b0));
    // bounds above 2^32: result wraps
    directed.push_back(row(OP_RANGE, SPAN_FULL, SPAN_FULL + 33'd1000, '0, '0));
    // span just over 2^31: about half the words are redrawn
    directed.push_back(row(OP_RANGE, '0, 33'h0_8000_0001, '0, '0));
    directed.push_back(row(OP_RANGE, 33'd100, SPAN_FULL, '0, '0));
    directed.push_back(fixed_row(OP_RANGE, 33'd1, BOUND_MAX, '0, '0, 32'd0, 1'b1));
    directed.push_back(fixed_row(OP_RANGE, SPAN_FULL, SPAN_FULL, '0, '0, 32'd0, 1'b1));
    directed.push_back(row(OP_RAW, '0, '0, '0, '0));

    foreach (directed[i]) offer_word(directed[i]);
    wait_drained();

    // Random part: mostly draws on a seeded generator, with full reseeds now
    // and then, stray seed writes, refused ranges and unused operations.
    while (n_rand < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        for (k = 0; k < 16; k++) begin
          s = noise_row();
          s.op = OP_SEED;
          s.idx = k[3:0];
          offer_word(s);
        end
        n_rand += 16;
      end else begin
        s = noise_row();
        if (r < 10) s.op = OP_SEED;
        else if (r < 45) s.op = OP_RAW;
        else if (r < 96) begin
          s.op = OP_RANGE;
          pick_bounds(s.low, s.high);
        end
        else s.op = OP_UNUSED;
        offer_word(s);
        n_rand++;
      end

      // Hold the receiver off for a long stretch while words keep coming, so
      // the block fills and stalls its input.
      if (n_rand >= 300 && !hold_done) begin
        hold_done = 1'b1;
        long_hold_req = 1'b1;
      end
      tx_calm = (n_rand >= 300 && n_rand < 340) || (n_rand >= 1200 && n_rand < 1350);
      rx_calm = (n_rand >= 1200 && n_rand < 1350);

      if (n_rand >= 950 && !paused) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
    // let any stray result show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
rtl/wrd_pkg.sv
rtl/wrd_div.sv
rtl/wrd_dp.sv
rtl/wrd_ctrl.sv
rtl/well512_ranged_random_draw.sv
rtl/wrd_chk.sv
bench/tb.sv
